/* sv/sv39ptw_pkg.sv */
// package for the sv39 page table walker: payload structs, codes, constants
// no dependencies
`timescale 1ns / 1ps
package sv39ptw_pkg;

	localparam int LEVEL_COUNT_DEF = 3;
	localparam int PTE_BYTES = 8;
	localparam int PAGE_SHIFT = 12;
	localparam int VPN_BITS = 9;
	localparam int PTE_PPN_SHIFT = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 44;

	localparam logic [CFG_IDX_W-1:0] REG_XLAT_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_PPN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MPRV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MPP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MXR = 3'd6;

	localparam logic OP_REQ = 1'b0;
	localparam logic OP_RSP = 1'b1;

	localparam logic [1:0] ACC_READ = 2'd0;
	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_EXEC = 2'd2;

	localparam logic [1:0] PRIV_U = 2'd0;
	localparam logic [1:0] PRIV_S = 2'd1;
	localparam logic [1:0] PRIV_M = 2'd3;

	localparam logic [1:0] KIND_RD = 2'd0;
	localparam logic [1:0] KIND_WB = 2'd1;
	localparam logic [1:0] KIND_FIN = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_LOAD_FAULT = 3'd1;
	localparam logic [2:0] ST_STORE_FAULT = 3'd2;
	localparam logic [2:0] ST_INST_FAULT = 3'd3;
	localparam logic [2:0] ST_BUS_ERR = 3'd4;

	localparam int FV = 0, FR = 1, FW = 2, FX = 3, FU = 4, FA = 6, FD = 7;

	typedef struct packed {
		logic        op;
		logic [38:0] virtual_address;
		logic [1:0]  access_kind;
		logic [63:0] pte_word;
		logic        bus_error;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [55:0] memory_address;
		logic [63:0] write_data;
		logic [43:0] physical_page;
		logic [7:0]  leaf_flags;
		logic [1:0]  page_level;
		logic [2:0]  status;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic        xlat_en;
		logic [43:0] root_ppn;
		logic [1:0]  priv;
		logic        mprv;
		logic [1:0]  mpp;
		logic        sum;
		logic        mxr;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        pass;      // untranslated request
		logic        start;     // start a walk
		logic [38:0] va;
		logic [1:0]  acc;
		logic [63:0] pte;
		logic        bus_error;
	} task_t;

	function automatic logic [2:0] fault_code(input logic [1:0] acc);
		case (acc)
			ACC_WRITE: fault_code = ST_STORE_FAULT;
			ACC_EXEC:  fault_code = ST_INST_FAULT;
			default:   fault_code = ST_LOAD_FAULT;
		endcase
	endfunction

endpackage

/* sv/sv39_page_table_walker.sv */
// top level of the sv39 page table walker: config registers, front, back
// depends on sv39ptw_pkg, sv39ptw_front, sv39ptw_back
`timescale 1ns / 1ps
// usage:
// - in channel: requests (op 0) and page table read responses (op 1) share
//   one valid/stall channel; a beat moves when in_valid is high and in_stall low
// - a request while a walk is pending, or a response with no walk pending,
//   is dropped with no result
// - out channel: entry read requests, write-backs and final results; a beat
//   moves when out_valid is high and out_stall low; last marks the final beat
//   caused by one input beat
// - an input beat is registered in the front queue and then in the output register;
//   a leaf that needs a write-back gives two beats, the write-back and then the
//   final result
// - throughput: one input beat a cycle while the queue is not full; the queue holds
//   two classified beats so input is still taken while the output register is stalled
// - a stalled output holds its beat; the queue fills and then in_stall rises
// - reset clears the queue, the walk and the registers (privilege to machine)
// - configuration writes take effect on the next cycle; write only when idle
module sv39_page_table_walker
	import sv39ptw_pkg::*;
#(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_beat_t              in_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	output out_beat_t             out_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t  cfg_q;
	task_t q_data;
	logic  q_valid, q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{xlat_en: 1'b0, root_ppn: 44'd0, priv: PRIV_M, mprv: 1'b0,
				mpp: PRIV_U, sum: 1'b0, mxr: 1'b0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_XLAT_EN:  cfg_q.xlat_en <= cfg_data[0];
				REG_ROOT_PPN: cfg_q.root_ppn <= cfg_data;
				REG_PRIV:     cfg_q.priv <= cfg_data[1:0];
				REG_MPRV:     cfg_q.mprv <= cfg_data[0];
				REG_MPP:      cfg_q.mpp <= cfg_data[1:0];
				REG_SUM:      cfg_q.sum <= cfg_data[0];
				REG_MXR:      cfg_q.mxr <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front classifies and drops, back walks
	sv39ptw_front #(.LEVEL_COUNT(LEVEL_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_valid(in_valid),
		.in_stall(in_stall), .xlat_en(cfg_q.xlat_en), .q_data(q_data),
		.q_valid(q_valid), .q_pop(q_pop)
	);

	sv39ptw_back #(.LEVEL_COUNT(LEVEL_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop), .cfg(cfg_q), .out_data(out_data), .out_valid(out_valid),
		.out_stall(out_stall)
	);
endmodule

/* sv/sv39ptw_front.sv */
// front: accepts input beats, drops ignored ones, queues the rest
// depends on sv39ptw_pkg
`timescale 1ns / 1ps
module sv39ptw_front
	import sv39ptw_pkg::*;
#(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_beat_t in_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     xlat_en,
	output task_t    q_data,
	output logic     q_valid,
	input  logic     q_pop
);
	localparam int LW = 2;
	localparam logic [LW-1:0] TOP_LEVEL = LW'(LEVEL_COUNT - 1);

	// 2-entry queue; busy_q tracks whether a response is outstanding
	task_t       mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic [LW-1:0] lvl_q;
	logic        acc, keep, push, ptr;
	task_t       t;

	assign in_stall = (cnt_q == 2'd2);
	assign acc = in_valid && !in_stall;
	assign keep = (in_data.op == OP_REQ) ? !busy_q : busy_q;
	assign push = acc && keep;

	// a clean response that points to a further table keeps the walk going
	assign ptr = !in_data.bus_error && in_data.pte_word[FV] && !in_data.pte_word[FR]
		&& !in_data.pte_word[FW] && !in_data.pte_word[FX];

	always_comb begin
		t.pass = (in_data.op == OP_REQ) && !xlat_en;
		t.start = (in_data.op == OP_REQ) && xlat_en;
		t.va = in_data.virtual_address;
		t.acc = in_data.access_kind;
		t.pte = in_data.pte_word;
		t.bus_error = in_data.bus_error;
	end

	assign q_data = mem_q[rd_q];
	assign q_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= t;
	end

	// busy state is a front-side mirror of the walk: a start sets it, a
	// response clears it unless it is a pointer above the last level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
			busy_q <= 1'b0;
			lvl_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
			if (push) begin
				if (t.start) begin
					busy_q <= 1'b1;
					lvl_q <= TOP_LEVEL;
				end else if (in_data.op == OP_RSP) begin
					busy_q <= ptr && (lvl_q != '0);
					if (ptr && (lvl_q != '0))
						lvl_q <= lvl_q - 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && !q_valid))
		else $error("pop on empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> lvl_q <= TOP_LEVEL)
		else $error("walk level out of range");
endmodule

/* sv/sv39ptw_back.sv */
// back: executes queued items, walks the table, emits result beats
// depends on sv39ptw_pkg
`timescale 1ns / 1ps
module sv39ptw_back
	import sv39ptw_pkg::*;
#(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  task_t     q_data,
	input  logic      q_valid,
	output logic      q_pop,
	input  cfg_t      cfg,
	output out_beat_t out_data,
	output logic      out_valid,
	input  logic      out_stall
);
	localparam int LW = 2;
	localparam logic [LW-1:0] TOP_LEVEL = LW'(LEVEL_COUNT - 1);

	logic [LW-1:0] lvl_q;
	logic [38:0]   va_q;
	logic [1:0]    accs_q;
	logic [55:0]   loc_q;
	out_beat_t     o_q, hold_q;
	logic          ov_q, hv_q;

	logic [LW-1:0] lvl_n;
	logic [55:0]   loc_n;
	out_beat_t     r0, r1;
	logic          two;

	function automatic logic [55:0] ent_addr(input logic [43:0] ppn, input logic [38:0] va,
			input logic [LW-1:0] l);
		logic [8:0] v;
		v = 9'(va >> (PAGE_SHIFT + VPN_BITS * int'(l)));
		ent_addr = {ppn, 12'd0} + 56'({v, 3'd0});
	endfunction

	function automatic logic [43:0] low_mask(input logic [LW-1:0] l);
		low_mask = 44'((64'd1 << (VPN_BITS * int'(l))) - 64'd1);
	endfunction

	logic [63:0] pte, npte;
	logic [7:0]  fl;
	logic [43:0] ppn, lm;
	logic [1:0]  ep;
	logic        isx, isw, ok, upd;
	logic [2:0]  fc;

	always_comb begin
		pte = q_data.pte;
		fl = pte[7:0];
		ppn = pte[53:10];
		lm = low_mask(lvl_q);
		isx = (accs_q == ACC_EXEC);
		isw = (accs_q == ACC_WRITE);
		fc = fault_code(accs_q);
		ep = (cfg.mprv && !isx) ? cfg.mpp : cfg.priv;
		ok = 1'b1;
		if (ep == PRIV_U && !fl[FU])
			ok = 1'b0;
		if (ep == PRIV_S && fl[FU] && (isx || !cfg.sum))
			ok = 1'b0;
		if (isw)
			ok = ok && fl[FW];
		else if (isx)
			ok = ok && fl[FX];
		else
			ok = ok && (fl[FR] || (cfg.mxr && fl[FX]));
		upd = !fl[FA] || (isw && !fl[FD]);
		npte = pte | 64'h40 | (isw ? 64'h80 : 64'h0);
		lvl_n = lvl_q;
		loc_n = loc_q;
		two = 1'b0;
		r0 = '0;
		r1 = '0;
		r0.kind = KIND_FIN;
		r0.last = 1'b1;
		if (q_data.pass) begin
			r0.physical_page = 44'(q_data.va >> PAGE_SHIFT);
		end else if (q_data.start) begin
			lvl_n = TOP_LEVEL;
			loc_n = ent_addr(cfg.root_ppn, q_data.va, TOP_LEVEL);
			r0.kind = KIND_RD;
			r0.memory_address = loc_n;
		end else if (q_data.bus_error) begin
			r0.status = ST_BUS_ERR;
		end else if (!fl[FV] || (!fl[FR] && fl[FW])) begin
			r0.status = fc;
		end else if (!fl[FR] && !fl[FX]) begin
			if (lvl_q == '0)
				r0.status = fc;
			else begin
				lvl_n = lvl_q - 1'b1;
				loc_n = ent_addr(ppn, va_q, lvl_n);
				r0.kind = KIND_RD;
				r0.memory_address = loc_n;
			end
		end else if (!ok || (ppn & lm) != '0) begin
			r0.status = fc;
		end else begin
			r1.kind = KIND_FIN;
			r1.last = 1'b1;
			r1.physical_page = ppn | (44'(va_q >> PAGE_SHIFT) & lm);
			r1.leaf_flags = upd ? npte[7:0] : fl;
			r1.page_level = lvl_q;
			if (upd) begin
				two = 1'b1;
				r0 = '0;
				r0.kind = KIND_WB;
				r0.memory_address = loc_q;
				r0.write_data = npte;
			end else
				r0 = r1;
		end
	end

	// output register plus one holding slot for a second beat
	assign q_pop = q_valid && !hv_q && (!ov_q || !out_stall);
	assign out_data = o_q;
	assign out_valid = ov_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			o_q <= r0;
			hold_q <= r1;
		end else if (hv_q && (!ov_q || !out_stall))
			o_q <= hold_q;
		if (q_pop && q_data.start) begin
			va_q <= q_data.va;
			accs_q <= q_data.acc;
		end
		if (q_pop)
			loc_q <= loc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			hv_q <= 1'b0;
			lvl_q <= '0;
		end else begin
			if (q_pop) begin
				ov_q <= 1'b1;
				hv_q <= two;
				lvl_q <= lvl_n;
			end else if (hv_q && (!ov_q || !out_stall)) begin
				ov_q <= 1'b1;
				hv_q <= 1'b0;
			end else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) hv_q |-> ov_q)
		else $error("held beat without output beat");
	assert property (@(posedge clk) disable iff (!arst_n) hv_q |-> o_q.kind == KIND_WB)
		else $error("held beat must follow write-back");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !hv_q)
		else $error("pop while second beat pending");
endmodule

/* sim/tb_sv39_page_table_walker.sv */
// testbench for the sv39 page table walker: directed table, directed walks, then random walks
// against a behavioral walk predictor; depends on sv39ptw_pkg and the rtl top
`timescale 1ns / 1ps
module tb_sv39_page_table_walker;
	import sv39ptw_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_beat_t in_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	out_beat_t out_data;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sv39_page_table_walker DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers and walk state
	cfg_t cfg_m;
	logic walking;
	int unsigned walk_level;
	logic [38:0] walk_va;
	logic [1:0] walk_acc;
	logic [55:0] walk_entry_addr;

	out_beat_t expected_beats[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	function automatic logic [55:0] entry_addr(logic [43:0] ppn, int unsigned lvl);
		logic [8:0] vpn;
		vpn = walk_va[PAGE_SHIFT + VPN_BITS*lvl +: VPN_BITS];
		return {ppn, 12'h000} + 56'(vpn) * PTE_BYTES;
	endfunction

	function automatic logic [2:0] access_fault(logic [1:0] acc);
		if (acc == ACC_WRITE) return ST_STORE_FAULT;
		if (acc == ACC_EXEC) return ST_INST_FAULT;
		return ST_LOAD_FAULT;
	endfunction

	function automatic bit leaf_permitted(logic [7:0] fl, logic [1:0] acc);
		logic [1:0] priv;
		bit exec;
		exec = (acc == ACC_EXEC);
		priv = (cfg_m.mprv && !exec) ? cfg_m.mpp : cfg_m.priv;
		if (priv == PRIV_U && !fl[FU]) return 0;
		if (priv == PRIV_S && fl[FU] && (exec || !cfg_m.sum)) return 0;
		if (acc == ACC_WRITE) return fl[FW];
		if (exec) return fl[FX];
		return fl[FR] || (cfg_m.mxr && fl[FX]);
	endfunction

	function automatic out_beat_t final_beat(logic [2:0] st);
		out_beat_t b;
		b = '0;
		b.kind = KIND_FIN;
		b.status = st;
		b.last = 1'b1;
		return b;
	endfunction

	// work out the result beats of one accepted input beat
	task automatic predict_walk(in_beat_t d);
		out_beat_t b;
		logic [63:0] pte;
		logic [7:0] fl;
		logic [43:0] ppn, low_mask;
		b = '0;
		if (d.op == OP_REQ) begin
			if (walking) return;
			if (!cfg_m.xlat_en) begin
				b = final_beat(ST_OK);
				b.physical_page = 44'(d.virtual_address >> PAGE_SHIFT);
				expected_beats.push_back(b);
				return;
			end
			walk_va = d.virtual_address;
			walk_acc = d.access_kind;
			walk_level = LEVEL_COUNT_DEF - 1;
			walk_entry_addr = entry_addr(cfg_m.root_ppn, walk_level);
			walking = 1'b1;
			b.kind = KIND_RD;
			b.memory_address = walk_entry_addr;
			b.last = 1'b1;
			expected_beats.push_back(b);
			return;
		end
		if (!walking) return;
		walking = 1'b0;
		if (d.bus_error) begin
			expected_beats.push_back(final_beat(ST_BUS_ERR));
			return;
		end
		pte = d.pte_word;
		fl = pte[7:0];
		ppn = pte[PTE_PPN_SHIFT +: 44];
		if (!fl[FV] || (!fl[FR] && fl[FW])) begin
			expected_beats.push_back(final_beat(access_fault(walk_acc)));
			return;
		end
		if (!fl[FR] && !fl[FX]) begin
			if (walk_level == 0) begin
				expected_beats.push_back(final_beat(access_fault(walk_acc)));
				return;
			end
			walk_level--;
			walk_entry_addr = entry_addr(ppn, walk_level);
			walking = 1'b1;
			b.kind = KIND_RD;
			b.memory_address = walk_entry_addr;
			b.last = 1'b1;
			expected_beats.push_back(b);
			return;
		end
		low_mask = (44'd1 << (VPN_BITS*walk_level)) - 44'd1;
		if (!leaf_permitted(fl, walk_acc) || (ppn & low_mask) != 0) begin
			expected_beats.push_back(final_beat(access_fault(walk_acc)));
			return;
		end
		if (!fl[FA] || (walk_acc == ACC_WRITE && !fl[FD])) begin
			pte[FA] = 1'b1;
			if (walk_acc == ACC_WRITE) pte[FD] = 1'b1;
			fl = pte[7:0];
			b.kind = KIND_WB;
			b.memory_address = walk_entry_addr;
			b.write_data = pte;
			expected_beats.push_back(b);
		end
		b = final_beat(ST_OK);
		b.physical_page = ppn | (44'(walk_va >> PAGE_SHIFT) & low_mask);
		b.leaf_flags = fl;
		b.page_level = 2'(walk_level);
		expected_beats.push_back(b);
	endtask

	// scoreboard on accepted output beats
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %p", out_data);
			end else begin
				out_beat_t e;
				e = expected_beats.pop_front();
				if (e.kind !== out_data.kind || e.memory_address !== out_data.memory_address
						|| e.write_data !== out_data.write_data
						|| e.physical_page !== out_data.physical_page
						|| e.leaf_flags !== out_data.leaf_flags
						|| e.page_level !== out_data.page_level
						|| e.status !== out_data.status || e.last !== out_data.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %p got %p", e, out_data);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stall pattern: each cycle picks no, light or heavy stalling; hold_off forces a stall
	always @(posedge clk) begin
		int unsigned phase;
		phase = ($urandom_range(0, 199) < 100) ? 0 : $urandom_range(1, 3);
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= (phase == 0) ? 1'b0 : ($urandom_range(0, 3) < phase);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_XLAT_EN: cfg_m.xlat_en = val[0];
			REG_ROOT_PPN: cfg_m.root_ppn = val;
			REG_PRIV: cfg_m.priv = val[1:0];
			REG_MPRV: cfg_m.mprv = val[0];
			REG_MPP: cfg_m.mpp = val[1:0];
			REG_SUM: cfg_m.sum = val[0];
			REG_MXR: cfg_m.mxr = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_pipe();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one beat held until taken; gap of random length between bursts
	// the predictor runs here, at the edge that takes the beat
	int burst_left = 0;
	task automatic send_beat(in_beat_t d);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (in_stall);
		predict_walk(d);
		burst_left--;
	endtask

	function automatic in_beat_t req_beat(logic [38:0] va, logic [1:0] acc);
		in_beat_t d;
		d = '0;
		d.op = OP_REQ;
		d.virtual_address = va;
		d.access_kind = acc;
		return d;
	endfunction

	function automatic in_beat_t rsp_beat(logic [63:0] pte, logic err);
		in_beat_t d;
		d = '0;
		d.op = OP_RSP;
		d.pte_word = pte;
		d.bus_error = err;
		return d;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random pte: pointer, leaf (aligned or not) or junk
	function automatic logic [63:0] pick_pte(int unsigned lvl);
		logic [63:0] p;
		int unsigned r;
		r = $urandom_range(0, 99);
		p = rand64();
		if (r < 35 && lvl > 0) begin
			p[7:0] = {$urandom_range(0, 7) == 0 ? 4'($urandom()) : 4'b0000, 4'b0001};
			p[3:1] = 3'b000;
		end else if (r < 90) begin
			p[0] = 1'b1;
			if (p[3:1] == 3'b000 || p[3:1] == 3'b010) p[1] = 1'b1;
			if ($urandom_range(0, 3) != 0 && lvl > 0)
				p[PTE_PPN_SHIFT +: 18] = p[PTE_PPN_SHIFT +: 18]
					& ~((18'd1 << (9*lvl)) - 18'd1);
		end
		return p;
	endfunction

	typedef struct {
		in_beat_t beat;
		bit checked;
		out_beat_t exp_beat;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		in_beat_t d;
		logic [63:0] p;
		int unsigned lvl, steps;
		cfg_m = '0;
		cfg_m.priv = PRIV_M;
		walking = 1'b0;
		walk_level = 0;
		walk_va = '0;
		walk_acc = '0;
		walk_entry_addr = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: pass-through after reset, extremes, stray response
		r.checked = 1;
		r.beat = req_beat('1, ACC_EXEC);
		r.exp_beat = final_beat(ST_OK);
		r.exp_beat.physical_page = 44'h7FFFFFF;
		rows.push_back(r);
		r.beat = req_beat('0, 2'd3);
		r.exp_beat = final_beat(ST_OK);
		rows.push_back(r);
		r.checked = 0;
		r.beat = rsp_beat('1, 1'b1);
		rows.push_back(r);
		foreach (rows[i]) begin
			send_beat(rows[i].beat);
			if (rows[i].checked && expected_beats.size() != 0
					&& expected_beats[$] !== rows[i].exp_beat) begin
				mismatches++;
				$display("table row %0d predicted %p", i, expected_beats[$]);
			end
		end
		in_valid <= 1'b0;
		drain_pipe();

		write_reg(REG_XLAT_EN, CFG_DATA_W'(1));
		write_reg(REG_ROOT_PPN, '1);
		write_reg(REG_PRIV, CFG_DATA_W'(PRIV_U));
		write_reg(REG_MPRV, CFG_DATA_W'(1));
		write_reg(REG_MPP, CFG_DATA_W'(PRIV_S));
		write_reg(REG_SUM, CFG_DATA_W'(1));
		write_reg(REG_MXR, CFG_DATA_W'(1));
		// directed walks: bus error, invalid, w without v, pointer to level zero
		// pointer at last level, aligned gigapage leaf, request during walk
		send_beat(req_beat('1, ACC_READ));
		send_beat(req_beat('0, ACC_WRITE));
		send_beat(rsp_beat('0, 1'b1));
		send_beat(req_beat('1, ACC_WRITE));
		send_beat(rsp_beat(64'h4, 1'b0));
		send_beat(req_beat('0, ACC_EXEC));
		send_beat(rsp_beat(64'h0, 1'b0));
		send_beat(req_beat(39'h1234567, 2'd3));
		send_beat(rsp_beat(64'h1, 1'b0));
		send_beat(rsp_beat(64'h1, 1'b0));
		send_beat(rsp_beat(64'h1, 1'b0));
		send_beat(req_beat('1, ACC_READ));
		send_beat(rsp_beat(64'h1F, 1'b0));
		send_beat(req_beat('1, ACC_WRITE));
		send_beat(rsp_beat({10'h3FF, 26'h0, 18'h0, 10'h0D7}, 1'b0));
		in_valid <= 1'b0;
		drain_pipe();

		// random phases through several register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_XLAT_EN, CFG_DATA_W'((ph == 7) ? 0 : 1));
			write_reg(REG_ROOT_PPN, (ph == 1) ? '0 : {$urandom(), 12'($urandom())});
			write_reg(REG_PRIV, CFG_DATA_W'($urandom_range(0, 3)));
			write_reg(REG_MPRV, CFG_DATA_W'($urandom_range(0, 1)));
			write_reg(REG_MPP, CFG_DATA_W'($urandom_range(0, 3)));
			write_reg(REG_SUM, CFG_DATA_W'($urandom_range(0, 1)));
			write_reg(REG_MXR, CFG_DATA_W'($urandom_range(0, 1)));
			if (ph == 3) fork
				begin
					hold_off = 1'b1;
					repeat (60) @(posedge clk);
					hold_off = 1'b0;
				end
			join_none
			steps = 0;
			while (steps < 50) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: stray beat of either sort
					d = $urandom_range(0, 1) ? rsp_beat(rand64(), $urandom_range(0, 1))
						: req_beat({$urandom(), 7'($urandom())}, 2'($urandom_range(0, 3)));
					send_beat(d);
					steps++;
					continue;
				end
				send_beat(req_beat({$urandom(), 7'($urandom())}, 2'($urandom_range(0, 3))));
				steps++;
				lvl = 2;
				while (walking) begin
					p = pick_pte(lvl);
					send_beat(rsp_beat(p, $urandom_range(0, 19) == 0));
					steps++;
					if (lvl > 0) lvl--;
				end
			end
			in_valid <= 1'b0;
			drain_pipe();
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
